[hdl/ffba_pkg.sv]
// Shared constants, operation codes and result type of the first-fit block allocator.
`default_nettype none
package ffba_pkg;
	localparam int MAX_PAGES_DEF = 16;
	localparam int PAGE_BYTES    = 4096;
	localparam int PAGE_SHIFT    = 12;
	localparam int HEADER_BYTES  = 12;
	localparam int ALIGN_BYTES   = 8;
	// Block starts always sit on 4-byte boundaries (header 12, sizes multiples of 4).
	localparam int GRAN_SHIFT    = 2;

	localparam int ADDR_W  = 32;
	localparam int REQ_W   = 16;
	localparam int SZ_W    = REQ_W + 1;
	localparam int STAT_W  = 17;
	localparam int PAGES_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [STAT_W-1:0] STAT_MAX   = '1;
	localparam logic [SZ_W-1:0]   ALIGN_MASK = ~SZ_W'(ALIGN_BYTES - 1);

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_STATS   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ARENA_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'd1;

	typedef struct packed {
		logic [ADDR_W-1:0]  data_address;
		logic               status;
		logic [PAGES_W-1:0] pages_in_use;
		logic [STAT_W-1:0]  used_total;
		logic [STAT_W-1:0]  free_total;
	} ffba_result_t;
endpackage
`default_nettype wire

[hdl/ffba_req_if.sv]
// Request channel: operation and its operands.
`default_nettype none
interface ffba_req_if;
	import ffba_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [REQ_W-1:0]  request_bytes;
	logic [ADDR_W-1:0] release_address;
	modport source (output valid, op, request_bytes, release_address, input ready);
	modport sink (input valid, op, request_bytes, release_address, output ready);
endinterface
`default_nettype wire

[hdl/ffba_rsp_if.sv]
// Response channel: one result transaction per request.
`default_nettype none
interface ffba_rsp_if;
	import ffba_pkg::*;
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  data_address;
	logic               status;
	logic [PAGES_W-1:0] pages_in_use;
	logic [STAT_W-1:0]  used_total;
	logic [STAT_W-1:0]  free_total;
	modport source (output valid, data_address, status, pages_in_use, used_total, free_total,
		input ready);
	modport sink (input valid, data_address, status, pages_in_use, used_total, free_total,
		output ready);
endinterface
`default_nettype wire

[hdl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: config registers, engine and result register.
//
// Usage: a request transaction on req carries op (0 allocate, 1 release, 2 statistics)
// with request_bytes or release_address; exactly one response transaction on rsp
// follows for each request, in order. Configuration (arena_base, page_limit) is
// written through cfg_we/cfg_index/cfg_wdata; the user must write it only while the
// block is idle, as the block does not enforce this. Allocate walks the block headers
// in the header memory, one block per cycle (registered read feeds the next header
// address), then grants pages one per cycle, then writes the taken header and, on a
// split, the remainder header. Release frees the block's header, then merges a free
// follower into it; statistics sums every block, one header read each on the single port.
// One transaction is worked on at a time; the next request is taken as soon as the
// engine is back to idle, even while the previous result still sits in the output
// register.
// Reset: clear every header entry, one entry per cycle over MAX_PAGES*1024 entries
// (16384 by default); req.ready stays low during that pass. Pages granted drop to zero.
// When rsp stalls, hold the result in the output register; a finished transaction then
// waits in the engine until the register frees up.
`default_nettype none
module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ffba_req_if.sink                  req,
	ffba_rsp_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_wdata
);
	logic [ADDR_W-1:0]  base_q;
	logic [PAGES_W-1:0] plim_q;
	logic               out_v_q;
	ffba_result_t       out_q;
	logic               fin_ready;
	logic               done;
	ffba_result_t       result;

	// Configuration registers; write them only while the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ADDR_W'(PAGE_BYTES);
			plim_q <= PAGES_W'(MAX_PAGES_DEF);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ARENA_BASE: base_q <= cfg_wdata;
				REG_PAGE_LIMIT: plim_q <= cfg_wdata[PAGES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The engine may hand over a result when the output register is empty or draining.
	assign fin_ready = !out_v_q || rsp.ready;

	ffba_engine #(.MAX_PAGES(MAX_PAGES)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.in_op        (req.op),
		.in_req_bytes (req.request_bytes),
		.in_rel_addr  (req.release_address),
		.arena_base   (base_q),
		.page_limit   (plim_q),
		.fin_ready    (fin_ready),
		.done         (done),
		.result       (result)
	);

	// Output register: load on a finished transaction, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (done) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= result;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.data_address = out_q.data_address;
	assign rsp.status       = out_q.status;
	assign rsp.pages_in_use = out_q.pages_in_use;
	assign rsp.used_total   = out_q.used_total;
	assign rsp.free_total   = out_q.free_total;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !rsp.ready) |-> !done)
		else $error("result overwritten while stalled");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !rsp.ready) |=> out_v_q && $stable(out_q))
		else $error("stalled result changed");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_v_q)
		else $error("finished transaction not presented");
endmodule
`default_nettype wire

[hdl/ffba_mem.sv]
// Single-port block header memory with registered read.
`default_nettype none
module ffba_mem #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 19
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule
`default_nettype wire

[hdl/ffba_engine.sv]
// Sequencer that walks, splits, grows and merges block headers in the header memory.
`default_nettype none
module ffba_engine
	import ffba_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         in_op,
	input  wire logic [REQ_W-1:0]   in_req_bytes,
	input  wire logic [ADDR_W-1:0]  in_rel_addr,
	input  wire logic [ADDR_W-1:0]  arena_base,
	input  wire logic [PAGES_W-1:0] page_limit,
	input  wire logic               fin_ready,
	output logic                    done,
	output ffba_result_t            result
);
	localparam int ARENA = MAX_PAGES * PAGE_BYTES;
	localparam int OW    = $clog2(ARENA + 1);
	localparam int PW    = $clog2(MAX_PAGES + 1);
	localparam int DEPTH = ARENA >> GRAN_SHIFT;
	localparam int IW    = $clog2(DEPTH);
	localparam int EW    = OW + 2;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;
	localparam logic [3:0] S_GROW  = 4'd3;
	localparam logic [3:0] S_TAKE  = 4'd4;
	localparam logic [3:0] S_SPLIT = 4'd5;
	localparam logic [3:0] S_REL0  = 4'd6;
	localparam logic [3:0] S_REL1  = 4'd7;
	localparam logic [3:0] S_REL2  = 4'd8;
	localparam logic [3:0] S_REL3  = 4'd9;
	localparam logic [3:0] S_REL4  = 4'd10;
	localparam logic [3:0] S_STAT  = 4'd11;
	localparam logic [3:0] S_FIN   = 4'd12;

	localparam logic [OW-1:0] PAGE_DATA = OW'(PAGE_BYTES - HEADER_BYTES);

	logic [3:0]        st_q;
	logic [IW-1:0]     clr_q;
	logic [SZ_W-1:0]   sz_q;
	logic [ADDR_W-1:0] rel_q;
	logic [OW-1:0]     off_q;
	logic [OW-1:0]     nxt_q;
	logic [OW-1:0]     have_q;
	logic [PW-1:0]     pages_q;
	logic [ADDR_W-1:0] addr_q;
	logic              status_q;
	logic [STAT_W-1:0] used_q;
	logic [STAT_W-1:0] free_q;

	logic          mem_we;
	logic          mem_re;
	logic [IW-1:0] mem_addr;
	logic [EW-1:0] mem_wdata;
	logic [EW-1:0] mem_rdata;

	logic          r_start;
	logic          r_free;
	logic [OW-1:0] r_size;
	logic [OW-1:0] end_w;
	logic [OW:0]   nxt_w;
	logic          nxt_out;
	logic [PW-1:0] lim_w;
	logic          split_w;
	logic [OW-1:0] rest_w;
	logic [33:0]   rel_diff;
	logic          rel_ok;
	logic [SZ_W-1:0] round_w;
	logic          accept;

	ffba_mem #(.DEPTH(DEPTH), .WIDTH(EW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign r_start = mem_rdata[OW+1];
	assign r_free  = mem_rdata[OW];
	assign r_size  = mem_rdata[OW-1:0];
	assign end_w   = OW'({pages_q, {PAGE_SHIFT{1'b0}}});
	assign nxt_w   = {1'b0, off_q} + (OW+1)'(HEADER_BYTES) + {1'b0, r_size};
	assign nxt_out = nxt_w >= {1'b0, end_w};
	assign lim_w   = (32'(page_limit) < 32'(MAX_PAGES)) ? PW'(page_limit) : PW'(MAX_PAGES);
	assign split_w = 32'(have_q) >= 32'(sz_q) + 32'(HEADER_BYTES) + 32'(ALIGN_BYTES);
	assign rest_w  = OW'(32'(off_q) + 32'(HEADER_BYTES) + 32'(sz_q));
	assign rel_diff = {2'b00, rel_q} - ({2'b00, arena_base} + 34'(HEADER_BYTES));
	assign rel_ok  = (rel_q != '0) && !rel_diff[33] && (rel_diff < 34'(end_w))
		&& (rel_diff[GRAN_SHIFT-1:0] == '0);
	assign round_w = ({1'b0, in_req_bytes} + SZ_W'(ALIGN_BYTES - 1)) & ALIGN_MASK;
	assign in_ready = (st_q == S_IDLE);
	assign accept  = in_valid && in_ready;
	assign done    = (st_q == S_FIN) && fin_ready;

	assign result.data_address = addr_q;
	assign result.status       = status_q;
	assign result.pages_in_use = PAGES_W'(pages_q);
	assign result.used_total   = used_q;
	assign result.free_total   = free_q;

	// Header memory access for the current step.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (st_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_IDLE: begin
				if (accept && ((in_op == OP_ALLOC && in_req_bytes != '0) || in_op == OP_STATS)
					&& pages_q != '0) begin
					mem_re = 1'b1;
				end
			end
			S_WALK, S_STAT: begin
				if (!(st_q == S_WALK && r_free && 32'(r_size) >= 32'(sz_q)) && !nxt_out) begin
					mem_re   = 1'b1;
					mem_addr = nxt_w[IW+GRAN_SHIFT-1:GRAN_SHIFT];
				end
			end
			S_GROW: begin
				if (pages_q < lim_w) begin
					mem_we    = 1'b1;
					mem_addr  = end_w[IW+GRAN_SHIFT-1:GRAN_SHIFT];
					mem_wdata = {1'b1, 1'b1, PAGE_DATA};
				end
			end
			S_TAKE: begin
				mem_we    = 1'b1;
				mem_addr  = off_q[IW+GRAN_SHIFT-1:GRAN_SHIFT];
				mem_wdata = {1'b1, 1'b0, split_w ? OW'(sz_q) : have_q};
			end
			S_SPLIT: begin
				mem_we    = 1'b1;
				mem_addr  = rest_w[IW+GRAN_SHIFT-1:GRAN_SHIFT];
				mem_wdata = {1'b1, 1'b1, OW'(32'(have_q) - 32'(sz_q) - 32'(HEADER_BYTES))};
			end
			S_REL0: begin
				if (rel_ok) begin
					mem_re   = 1'b1;
					mem_addr = rel_diff[IW+GRAN_SHIFT-1:GRAN_SHIFT];
				end
			end
			S_REL1: begin
				if (r_start) begin
					mem_we    = 1'b1;
					mem_addr  = off_q[IW+GRAN_SHIFT-1:GRAN_SHIFT];
					mem_wdata = {1'b1, 1'b1, r_size};
				end
			end
			S_REL2: begin
				mem_re   = 1'b1;
				mem_addr = nxt_q[IW+GRAN_SHIFT-1:GRAN_SHIFT];
			end
			S_REL3: begin
				if (r_start && r_free) begin
					mem_we    = 1'b1;
					mem_addr  = off_q[IW+GRAN_SHIFT-1:GRAN_SHIFT];
					mem_wdata = {1'b1, 1'b1,
						OW'(32'(have_q) + 32'(HEADER_BYTES) + 32'(r_size))};
				end
			end
			S_REL4: begin
				mem_we   = 1'b1;
				mem_addr = nxt_q[IW+GRAN_SHIFT-1:GRAN_SHIFT];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_CLEAR;
			clr_q   <= '0;
			pages_q <= '0;
		end else begin
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(DEPTH - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						addr_q   <= '0;
						status_q <= 1'b0;
						used_q   <= '0;
						free_q   <= '0;
						off_q    <= '0;
						sz_q     <= round_w;
						rel_q    <= in_rel_addr;
						priority if (in_op == OP_ALLOC) begin
							if (in_req_bytes == '0) begin
								status_q <= 1'b1;
								st_q     <= S_FIN;
							end else begin
								st_q <= (pages_q == '0) ? S_GROW : S_WALK;
							end
						end else if (in_op == OP_RELEASE) begin
							st_q <= S_REL0;
						end else if (in_op == OP_STATS) begin
							st_q <= (pages_q == '0) ? S_FIN : S_STAT;
						end else begin
							status_q <= 1'b1;
							st_q     <= S_FIN;
						end
					end
				end
				S_WALK: begin
					if (r_free && 32'(r_size) >= 32'(sz_q)) begin
						have_q <= r_size;
						st_q   <= S_TAKE;
					end else if (nxt_out) begin
						st_q <= S_GROW;
					end else begin
						off_q <= nxt_w[OW-1:0];
					end
				end
				S_GROW: begin
					if (pages_q < lim_w) begin
						pages_q <= pages_q + 1'b1;
						off_q   <= end_w;
						if (32'(PAGE_DATA) >= 32'(sz_q)) begin
							have_q <= PAGE_DATA;
							st_q   <= S_TAKE;
						end
					end else begin
						status_q <= 1'b1;
						st_q     <= S_FIN;
					end
				end
				S_TAKE: begin
					addr_q <= arena_base + 32'(off_q) + 32'(HEADER_BYTES);
					st_q   <= split_w ? S_SPLIT : S_FIN;
				end
				S_SPLIT: begin
					st_q <= S_FIN;
				end
				S_REL0: begin
					off_q <= rel_diff[OW-1:0];
					st_q  <= rel_ok ? S_REL1 : S_FIN;
				end
				S_REL1: begin
					have_q <= r_size;
					nxt_q  <= nxt_w[OW-1:0];
					st_q   <= (r_start && !nxt_out) ? S_REL2 : S_FIN;
				end
				S_REL2: begin
					st_q <= S_REL3;
				end
				S_REL3: begin
					st_q <= (r_start && r_free) ? S_REL4 : S_FIN;
				end
				S_REL4: begin
					st_q <= S_FIN;
				end
				S_STAT: begin
					if (r_free) begin
						free_q <= (32'(free_q) + 32'(r_size) > 32'(STAT_MAX)) ? STAT_MAX
							: STAT_W'(32'(free_q) + 32'(r_size));
					end else begin
						used_q <= (32'(used_q) + 32'(r_size) > 32'(STAT_MAX)) ? STAT_MAX
							: STAT_W'(32'(used_q) + 32'(r_size));
					end
					if (nxt_out) begin
						st_q <= S_FIN;
					end else begin
						off_q <= nxt_w[OW-1:0];
					end
				end
				S_FIN: begin
					if (fin_ready) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re))
		else $error("header memory read and write in the same cycle");
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> st_q != S_IDLE)
		else $error("accepted transaction did not start");
	a_page_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pages_q) <= 32'(MAX_PAGES))
		else $error("granted pages exceed the arena");
	a_grow_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_GROW && pages_q < lim_w) |=> pages_q == $past(pages_q) + 1'b1)
		else $error("page grant did not advance the page count");
endmodule
`default_nettype wire

[tb/ffba_checker.sv]
// Checker for the block allocator: tracks the arena, predicts each response and compares.
`timescale 1ns / 1ps
`default_nettype none
module ffba_checker
	import ffba_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ffba_req_if                       req,
	ffba_rsp_if                       rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_W-1:0]    cfg_wdata,
	output int                        errors,
	output int                        outstanding
);
	localparam int ARENA = MAX_PAGES_DEF * PAGE_BYTES;

	int unsigned blk_size [ARENA];
	bit          blk_start[ARENA];
	bit          blk_free [ARENA];
	int unsigned pages;
	logic [ADDR_W-1:0]  base;
	logic [PAGES_W-1:0] limit;
	ffba_result_t expected_rsp[$];

	function automatic int unsigned arena_top();
		return pages * PAGE_BYTES;
	endfunction

	function automatic logic [ADDR_W-1:0] claim_block(int unsigned off, int unsigned sz);
		int unsigned have, rest;
		have = blk_size[off];
		blk_free[off] = 1'b0;
		if (have >= sz + HEADER_BYTES + ALIGN_BYTES) begin
			rest = off + HEADER_BYTES + sz;
			if (rest < ARENA) begin
				blk_size[rest] = have - sz - HEADER_BYTES;
				blk_start[rest] = 1'b1;
				blk_free[rest] = 1'b1;
				blk_size[off] = sz;
			end
		end
		return base + ADDR_W'(off + HEADER_BYTES);
	endfunction

	// Return 0 on failure, else the granted data address.
	function automatic logic [ADDR_W-1:0] first_fit(int unsigned nbytes, output bit ok);
		int unsigned sz, off, lim;
		ok = 1'b0;
		if (nbytes == 0)
			return '0;
		sz = ((nbytes + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
		off = 0;
		while (off < arena_top() && off < ARENA && blk_start[off]) begin
			if (blk_free[off] && blk_size[off] >= sz) begin
				ok = 1'b1;
				return claim_block(off, sz);
			end
			off = off + HEADER_BYTES + blk_size[off];
		end
		lim = (limit < MAX_PAGES_DEF) ? limit : MAX_PAGES_DEF;
		while (pages < lim) begin
			off = arena_top();
			pages++;
			blk_size[off] = PAGE_BYTES - HEADER_BYTES;
			blk_start[off] = 1'b1;
			blk_free[off] = 1'b1;
			if (blk_size[off] >= sz) begin
				ok = 1'b1;
				return claim_block(off, sz);
			end
		end
		return '0;
	endfunction

	function automatic void release_block(logic [ADDR_W-1:0] a);
		longint unsigned lo;
		int unsigned off, nxt;
		lo = longint'(base) + HEADER_BYTES;
		if (a == 0 || longint'(a) < lo)
			return;
		if (longint'(a) - lo >= arena_top())
			return;
		off = int'(longint'(a) - lo);
		if (!blk_start[off])
			return;
		blk_free[off] = 1'b1;
		nxt = off + HEADER_BYTES + blk_size[off];
		if (nxt < arena_top() && nxt < ARENA && blk_start[nxt] && blk_free[nxt]) begin
			blk_size[off] += HEADER_BYTES + blk_size[nxt];
			blk_start[nxt] = 1'b0;
			blk_free[nxt] = 1'b0;
		end
	endfunction

	function automatic void sum_blocks(output logic [STAT_W-1:0] used,
			output logic [STAT_W-1:0] fre);
		longint unsigned u, f;
		int unsigned off;
		u = 0;
		f = 0;
		off = 0;
		while (off < arena_top() && off < ARENA && blk_start[off]) begin
			if (blk_free[off])
				f += blk_size[off];
			else
				u += blk_size[off];
			off = off + HEADER_BYTES + blk_size[off];
		end
		used = (u > STAT_MAX) ? STAT_MAX : STAT_W'(u);
		fre = (f > STAT_MAX) ? STAT_MAX : STAT_W'(f);
	endfunction

	function automatic ffba_result_t predict_result(logic [1:0] op, logic [REQ_W-1:0] nbytes,
			logic [ADDR_W-1:0] addr);
		ffba_result_t r;
		bit ok;
		r = '0;
		case (op)
			OP_ALLOC: begin
				r.data_address = first_fit(nbytes, ok);
				r.status = !ok;
				if (!ok)
					r.data_address = '0;
			end
			OP_RELEASE: release_block(addr);
			OP_STATS: sum_blocks(r.used_total, r.free_total);
			default: r.status = 1'b1;
		endcase
		r.pages_in_use = PAGES_W'(pages);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ffba_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < ARENA; i++) begin
				blk_start[i] = 1'b0;
				blk_free[i] = 1'b0;
				blk_size[i] = 0;
			end
			pages = 0;
			base = 32'd4096;
			limit = 5'd16;
			expected_rsp.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ARENA_BASE)
					base = cfg_wdata;
				else if (cfg_index == REG_PAGE_LIMIT)
					limit = cfg_wdata[PAGES_W-1:0];
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response with none expected: addr %h status %0d", $time,
						rsp.data_address, rsp.status);
					errors++;
				end else begin
					exp_r = expected_rsp.pop_front();
					if (rsp.data_address !== exp_r.data_address) begin
						$display("%0t: data_address expected %h actual %h", $time,
							exp_r.data_address, rsp.data_address);
						errors++;
					end
					if (rsp.status !== exp_r.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							exp_r.status, rsp.status);
						errors++;
					end
					if (rsp.pages_in_use !== exp_r.pages_in_use) begin
						$display("%0t: pages_in_use expected %0d actual %0d", $time,
							exp_r.pages_in_use, rsp.pages_in_use);
						errors++;
					end
					if (rsp.used_total !== exp_r.used_total) begin
						$display("%0t: used_total expected %0d actual %0d", $time,
							exp_r.used_total, rsp.used_total);
						errors++;
					end
					if (rsp.free_total !== exp_r.free_total) begin
						$display("%0t: free_total expected %0d actual %0d", $time,
							exp_r.free_total, rsp.free_total);
						errors++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_rsp.push_back(predict_result(req.op, req.request_bytes,
					req.release_address));
			outstanding = expected_rsp.size();
		end
	end
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench top: clock, reset, request and config stimulus, response stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import ffba_pkg::*;

	// op code 3 is not defined by the block; it must answer with a failure status
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0] cfg_wdata;
	int errors;
	int outstanding;
	int sent_count;
	int setting_count;
	int alloc_count;
	int release_count;
	int stats_count;
	int burst_left;
	int stall_mode;
	int stall_left;
	logic [ADDR_W-1:0] live_addrs[$];

	ffba_req_if req_ch();
	ffba_rsp_if rsp_ch();

	first_fit_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	ffba_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	// Hard stop: the reset clearing pass plus ~700 walks with long stalls fit well inside this.
	initial begin
		#200_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Remember every granted address so releases can hit real blocks.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready && rsp_ch.data_address != 0)
			live_addrs.push_back(rsp_ch.data_address);
	end

	// Response stalls: switch between always ready, random, and long stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_left <= $urandom_range(20, 200);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	// Send one transaction; valid stays up inside a burst and drops for a random gap after.
	task automatic send_req(logic [1:0] op, logic [REQ_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.request_bytes <= nbytes;
		req_ch.release_address <= addr;
		do @(posedge clk); while (!req_ch.ready);
		sent_count++;
		case (op)
			OP_ALLOC: alloc_count++;
			OP_RELEASE: release_count++;
			OP_STATS: stats_count++;
			default: ;
		endcase
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	// Stop sending and hold off until every response is back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_arena(logic [ADDR_W-1:0] base_addr, logic [PAGES_W-1:0] lim);
		drain();
		write_reg(REG_ARENA_BASE, base_addr);
		write_reg(REG_PAGE_LIMIT, ADDR_W'(lim));
		setting_count++;
	endtask

	function automatic logic [ADDR_W-1:0] pick_live(bit keep);
		int k;
		logic [ADDR_W-1:0] a;
		if (live_addrs.size() == 0)
			return 32'h0;
		k = $urandom_range(0, live_addrs.size() - 1);
		a = live_addrs[k];
		if (!keep)
			live_addrs.delete(k);
		return a;
	endfunction

	task automatic random_item();
		int r;
		logic [REQ_W-1:0] nbytes;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			if ($urandom_range(0, 19) == 0)
				nbytes = REQ_W'($urandom_range(0, 65535));
			else if ($urandom_range(0, 29) == 0)
				nbytes = '0;
			else
				nbytes = REQ_W'($urandom_range(1, 600));
			send_req(OP_ALLOC, nbytes, $urandom);
		end else if (r < 85) begin
			if ($urandom_range(0, 19) == 0)
				send_req(OP_RELEASE, REQ_W'($urandom), $urandom);
			else
				send_req(OP_RELEASE, REQ_W'($urandom), pick_live($urandom_range(0, 9) == 0));
		end else if (r < 96) begin
			send_req(OP_STATS, REQ_W'($urandom), $urandom);
		end else begin
			send_req(OP_UNKNOWN, REQ_W'($urandom), $urandom);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] first_blk;
		logic [ADDR_W-1:0] second_blk;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ALLOC;
		req_ch.request_bytes = '0;
		req_ch.release_address = '0;
		sent_count = 0;
		setting_count = 0;
		alloc_count = 0;
		release_count = 0;
		stats_count = 0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset arena settings, size edges, null request, odd ops, bad releases.
		set_arena(32'd4096, 5'd16);
		send_req(OP_STATS, '0, '0);
		send_req(OP_ALLOC, 16'd0, '0);
		send_req(OP_ALLOC, 16'd1, '0);
		send_req(OP_ALLOC, 16'd8, '0);
		send_req(OP_ALLOC, 16'd9, '0);
		send_req(OP_ALLOC, 16'd4084, '0);
		send_req(OP_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF);
		send_req(OP_RELEASE, '0, 32'h0);
		send_req(OP_RELEASE, '0, 32'hDEAD_BEEF);
		send_req(OP_STATS, '0, '0);
		drain();
		first_blk = live_addrs[0];
		second_blk = live_addrs[1];
		// Double release, then release the follower so the first one merges forward.
		send_req(OP_RELEASE, '0, first_blk);
		send_req(OP_RELEASE, '0, first_blk);
		send_req(OP_RELEASE, '0, second_blk);
		send_req(OP_RELEASE, '0, first_blk);
		send_req(OP_RELEASE, '0, first_blk + 32'd4);
		send_req(OP_STATS, '0, '0);
		live_addrs.delete(0);
		live_addrs.delete(0);

		// Oversized request under a small limit: grants pages until refused.
		set_arena(32'd4096, 5'd4);
		send_req(OP_ALLOC, 16'hFFFF, '0);
		send_req(OP_ALLOC, 16'd4085, '0);
		send_req(OP_STATS, '0, '0);

		// Limit zero at base zero: only the pages already granted are usable.
		set_arena(32'h0, 5'd0);
		send_req(OP_ALLOC, 16'd100, '0);
		send_req(OP_ALLOC, 16'd4000, '0);
		send_req(OP_STATS, '0, '0);

		// Random phases over several arena settings, the extremes among them.
		set_arena(32'd4096, 5'd8);
		repeat (170) random_item();
		set_arena(32'hFFFF_F000, 5'd31);
		repeat (90) random_item();
		drain();
		repeat (90) random_item();
		set_arena({20'($urandom_range(1, 32'hF_FFFE)), 12'h000},
			PAGES_W'($urandom_range(1, 15)));
		repeat (170) random_item();
		set_arena(32'h0, 5'd16);
		repeat (170) random_item();

		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d requests (%0d allocates, %0d releases, %0d statistics)",
			sent_count, alloc_count, release_count, stats_count);
		$display("over %0d arena settings with random sender gaps and receiver stalls.",
			setting_count);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
